// File: hdl/tpt_pkg.sv
// Package for the touch press / typematic block.
// Types, codes and constants shared by the controller, datapath and modulo unit.
package tpt_pkg;

  // Key states; the code is what a result beat carries in tuser
  typedef enum logic [2:0] {
    KS_PRESSED   = 3'd0,
    KS_RELEASED  = 3'd1,
    KS_CANCEL    = 3'd2,
    KS_TYPEMATIC = 3'd3,
    KS_SUPERKEY  = 3'd4,
    KS_IDLE      = 3'd5,
    KS_TRANSIT   = 3'd6
  } key_state_e;

  // Hold events fed to the key state machine
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PRESSED   = 3'd1,
    EV_SUPERKEY  = 3'd2,
    EV_TYPEMATIC = 3'd3,
    EV_SAME      = 3'd4,
    EV_EXIT      = 3'd5
  } hold_ev_e;

  // Sequencer states
  typedef enum logic [1:0] {
    CS_IDLE  = 2'd0,
    CS_START = 2'd1,
    CS_DIV   = 2'd2,
    CS_EVAL  = 2'd3
  } ctl_state_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRESS        = 2'd0;
  localparam logic [1:0] CFG_SUPERKEY     = 2'd1;
  localparam logic [1:0] CFG_REPEAT_START = 2'd2;
  localparam logic [1:0] CFG_REPEAT_PER   = 2'd3;

  localparam int unsigned HOLD_W  = 32;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned ZONE_W  = 16;
  localparam int unsigned DIGIT_W = 8;                 // dividend bits per modulo step
  localparam int unsigned MOD_STEPS = HOLD_W / DIGIT_W;

  localparam logic [1:0] RELEASE_TICKS = 2'd2;

  localparam logic [15:0] PRESS_RST        = 16'd2;
  localparam logic [15:0] SUPERKEY_RST     = 16'd100;
  localparam logic [15:0] REPEAT_START_RST = 16'd30;
  localparam logic [15:0] REPEAT_PER_RST   = 16'd10;

  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic div_start;  // load the modulo unit with the hold count
    logic eval;       // classify, step the key state, emit result
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;   // last modulo step completes this cycle
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

// File: hdl/tpt_mod.sv
// Iterative remainder unit: 32-bit dividend by 16-bit divisor, one byte a cycle.
// Depends on tpt_pkg.
module tpt_mod import tpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HOLD_W-1:0] dividend_i,
  input  logic [TICK_W-1:0] divisor_i,
  output logic              done_o,
  output logic [TICK_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(MOD_STEPS);

  logic [HOLD_W-1:0] dvd_q, dvd_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [TICK_W:0]   trial;
  logic [TICK_W-1:0] part;

  // restoring step over the top byte of the dividend
  always_comb begin
    part = rem_q;
    trial = '0;
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      trial = {part, dvd_q[HOLD_W-DIGIT_W+k]};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      part = trial[TICK_W-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(MOD_STEPS - 1));
  assign rem_o  = rem_q;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[HOLD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      rem_d = part;
      cnt_d = cnt_q + CNT_W'(1);
      if (done_o) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

endmodule

// File: hdl/tpt_ctrl.sv
// Sequencer for the touch press block: accept, modulo, evaluate.
// Depends on tpt_pkg.
module tpt_ctrl import tpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE:  if (in_valid_i) state_d = CS_START;
      CS_START: state_d = CS_DIV;
      CS_DIV:   if (sts_i.div_done) state_d = CS_EVAL;
      CS_EVAL:  if (sts_i.out_free) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      CS_START: cmd_o.div_start = 1'b1;
      CS_EVAL:  cmd_o.eval      = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/tpt_dp.sv
// Datapath: config registers, hold tracking, event classification, key state, output beat.
// Depends on tpt_pkg and tpt_mod.
module tpt_dp import tpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  input  logic              touched_i,
  input  logic              zone_valid_i,
  input  logic [ZONE_W-1:0] zone_id_i,
  input  ctl_cmd_t          cmd_i,
  output dp_sts_t           sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_event_o,
  output logic [ZONE_W-1:0] out_widget_o
);

  logic [TICK_W-1:0] press_q, superkey_q, rep_start_q, rep_per_q;

  logic [HOLD_W-1:0] hc_q, hc_d;
  logic [1:0]        rd_q, rd_d;
  logic [1:0]        rd_inc;
  logic [ZONE_W-1:0] hz_q, hz_d, hz_new;
  logic              hzv_q, hzv_d, hzv_new;
  logic [ZONE_W-1:0] lz_q, lz_d;
  logic              skf_q, skf_d;
  logic              cls_q, cls_d;      // event comes from the hold count
  hold_ev_e          pev_q, pev_d;      // event when not classified
  hold_ev_e          lev_q, lev_d;
  hold_ev_e          ev;
  key_state_e        ks_q, ks_d;
  logic [TICK_W-1:0] rem;
  logic              div_done;
  logic              emit;
  logic              ov_q;
  logic [2:0]        oev_q;
  logic [ZONE_W-1:0] owid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q     <= PRESS_RST;
      superkey_q  <= SUPERKEY_RST;
      rep_start_q <= REPEAT_START_RST;
      rep_per_q   <= REPEAT_PER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESS:        press_q     <= cfg_data_i;
        CFG_SUPERKEY:     superkey_q  <= cfg_data_i;
        CFG_REPEAT_START: rep_start_q <= cfg_data_i;
        CFG_REPEAT_PER:   rep_per_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (hc_q),
    .divisor_i  (rep_per_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign rd_inc = rd_q + 2'd1;

  // tick update on acceptance; superkey flag also set on evaluation
  always_comb begin
    hc_d    = hc_q;
    rd_d    = rd_q;
    hz_d    = hz_q;
    hzv_d   = hzv_q;
    lz_d    = lz_q;
    skf_d   = skf_q;
    cls_d   = cls_q;
    pev_d   = pev_q;
    hz_new  = hzv_q ? hz_q : (zone_valid_i ? zone_id_i : '0);
    hzv_new = hzv_q | zone_valid_i;
    if (cmd_i.accept) begin
      if (touched_i) begin
        rd_d = '0;
        if (zone_valid_i && hzv_new && (zone_id_i == hz_new)) begin
          hc_d  = hc_q + HOLD_W'(1);
          lz_d  = zone_id_i;
          hz_d  = hz_new;
          hzv_d = hzv_new;
          cls_d = 1'b1;
        end else begin
          hz_d  = '0;
          hzv_d = 1'b0;
          cls_d = 1'b0;
          pev_d = EV_EXIT;
        end
      end else begin
        cls_d = 1'b0;
        pev_d = lev_q;   // first untouched tick keeps the event
        if (rd_inc == RELEASE_TICKS) begin
          rd_d  = '0;
          hc_d  = '0;
          hz_d  = '0;
          hzv_d = 1'b0;
          skf_d = 1'b0;
          pev_d = EV_NONE;
        end else begin
          rd_d = rd_inc;
        end
      end
    end
    if (cmd_i.eval && (ks_q == KS_SUPERKEY)) begin
      skf_d = 1'b1;
    end
  end

  // press first, then superkey, then repeat
  always_comb begin
    if (!cls_q) begin
      ev = pev_q;
    end else if (hc_q == HOLD_W'(press_q)) begin
      ev = EV_PRESSED;
    end else if (hc_q == HOLD_W'(superkey_q)) begin
      ev = EV_SUPERKEY;
    end else if ((hc_q > HOLD_W'(rep_start_q)) && (rep_per_q != '0) && (rem == '0)) begin
      ev = EV_TYPEMATIC;
    end else begin
      ev = EV_SAME;
    end
  end

  always_comb begin
    ks_d = ks_q;
    case (ks_q)
      KS_RELEASED, KS_CANCEL, KS_IDLE: begin
        ks_d = (ev == EV_PRESSED) ? KS_PRESSED : KS_IDLE;
      end
      KS_PRESSED: begin
        if (ev == EV_NONE)           ks_d = KS_RELEASED;
        else if (ev == EV_EXIT)      ks_d = KS_CANCEL;
        else if (ev == EV_SAME)      ks_d = KS_TRANSIT;
        else if (ev == EV_TYPEMATIC) ks_d = KS_TYPEMATIC;
      end
      KS_TYPEMATIC, KS_SUPERKEY: begin
        if (ev == EV_NONE)      ks_d = KS_RELEASED;
        else if (ev == EV_EXIT) ks_d = KS_CANCEL;
        else if (ev == EV_SAME) ks_d = KS_TRANSIT;
      end
      KS_TRANSIT: begin
        if (ev == EV_NONE)                       ks_d = KS_RELEASED;
        else if (ev == EV_EXIT)                  ks_d = KS_CANCEL;
        else if (ev == EV_TYPEMATIC)             ks_d = KS_TYPEMATIC;
        else if (ev == EV_SUPERKEY && !skf_q)    ks_d = KS_SUPERKEY;
      end
      default: ;
    endcase
  end

  assign emit  = ks_d inside {[KS_PRESSED:KS_SUPERKEY]};
  assign lev_d = cmd_i.eval ? ev : lev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= '0;
      rd_q  <= '0;
      hz_q  <= '0;
      hzv_q <= 1'b0;
      lz_q  <= '0;
      skf_q <= 1'b0;
      cls_q <= 1'b0;
      pev_q <= EV_NONE;
      lev_q <= EV_NONE;
      ks_q  <= KS_IDLE;
      ov_q  <= 1'b0;
    end else begin
      hc_q  <= hc_d;
      rd_q  <= rd_d;
      hz_q  <= hz_d;
      hzv_q <= hzv_d;
      lz_q  <= lz_d;
      skf_q <= skf_d;
      cls_q <= cls_d;
      pev_q <= pev_d;
      lev_q <= lev_d;
      if (cmd_i.eval) begin
        ks_q <= ks_d;
      end
      if (cmd_i.eval && emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && emit) begin
      oev_q  <= ks_d;
      owid_q <= lz_q;
    end
  end

  always_comb begin
    sts_o.div_done = div_done;
    sts_o.out_free = !ov_q || out_ready_i;
  end

  assign out_valid_o    = ov_q;
  assign out_event_o    = oev_q;
  assign out_widget_o   = owid_q;

endmodule

// File: hdl/touch_press_typematic_fsm.sv
// Touch press / typematic event generator, top level.
// Depends on tpt_pkg, tpt_ctrl and tpt_dp.
//
// One input beat per touch tick on the slave stream: tuser[0] touched,
// tuser[1] zone valid, tdata the zone id. A tick yields zero or one beat on
// the master stream: tuser the key event (0 pressed, 1 released, 2 cancel,
// 3 typematic, 4 superkey), tdata the widget id last held.
// Thresholds are set through the write port (index 0 press, 1 superkey,
// 2 repeat start, 3 repeat period); write only while the block is idle.
//
// Each tick steps the sequencer through idle, which takes the beat, start,
// which loads the remainder unit, div, which forms the hold count modulo the
// repeat period (one byte of the 32-bit count a cycle), and eval, which
// classifies and steps the key state. The result beat is registered at the
// end of eval. s_axis_tready is high only in idle, so a new beat is not
// taken until the previous tick has passed eval.
// The result sits in an output register; the next tick is accepted while it
// waits, and is held in eval only if the previous result has not been taken.
// Reset puts the key state in idle, clears hold tracking and loads the
// default thresholds (2, 100, 30, 10).
module touch_press_typematic_fsm import tpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // zone_id
  input  logic [1:0]  s_axis_tuser,   // touched, zone_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // widget_id
  output logic [2:0]  m_axis_tuser    // touch_event
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  tpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .touched_i    (s_axis_tuser[0]),
    .zone_valid_i (s_axis_tuser[1]),
    .zone_id_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_event_o  (m_axis_tuser),
    .out_widget_o (m_axis_tdata)
  );

endmodule

// File: hdl/tpt_chk.sv
// Port-level checker for the touch press block, bound to the top level.
// Depends on touch_press_typematic_fsm.
module tpt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one tick at a time
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a tick is in progress");

  // only event codes 0..4 leave the block
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= 3'd4))
    else $error("idle or transit code emitted");

  // result cannot appear right after acceptance
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early after acceptance");

endmodule

bind touch_press_typematic_fsm tpt_chk u_tpt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_touch_press_typematic_fsm.sv
// Testbench for touch_press_typematic_fsm: predicts key events per tick and checks each beat.
// Depends on tpt_pkg and the block's RTL only; drives both streams with random idling.
`timescale 1ns / 1ps

module tb_touch_press_typematic_fsm;
  import tpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 16;   // covers a full tick plus the output register
  localparam logic [1:0] DEBOUNCE_TICKS = 2'd2;

  typedef struct packed {
    key_state_e  ev;
    logic [15:0] widget;
  } key_result_t;

  // Tracks the key state machine and holds the events still to come out
  class key_event_scoreboard;
    logic [15:0] press_thr, super_thr, rep_start, rep_period;
    key_state_e  key_st;
    hold_ev_e    last_ev;
    logic [31:0] hold_cnt;
    logic [1:0]  rel_cnt;
    logic [15:0] held_zone, last_zone;
    bit          held_ok, super_done;
    key_result_t due_q[$];
    int unsigned n_err;

    function new();
      press_thr  = 16'd2;
      super_thr  = 16'd100;
      rep_start  = 16'd30;
      rep_period = 16'd10;
      key_st     = KS_IDLE;
      last_ev    = EV_NONE;
      hold_cnt   = '0;
      rel_cnt    = '0;
      held_zone  = '0;
      last_zone  = '0;
      held_ok    = 1'b0;
      super_done = 1'b0;
      n_err      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_PRESS:        press_thr  = val;
        CFG_SUPERKEY:     super_thr  = val;
        CFG_REPEAT_START: rep_start  = val;
        CFG_REPEAT_PER:   rep_period = val;
        default: ;
      endcase
    endfunction

    // press beats superkey, superkey beats repeat
    function hold_ev_e classify(logic [31:0] n);
      if (n == {16'd0, press_thr}) return EV_PRESSED;
      if (n == {16'd0, super_thr}) return EV_SUPERKEY;
      if (n > {16'd0, rep_start} && rep_period != 16'd0 && (n % {16'd0, rep_period}) == 0)
        return EV_TYPEMATIC;
      return EV_SAME;
    endfunction

    function void note_tick(bit touched, bit zvalid, logic [15:0] zone);
      hold_ev_e    ev;
      key_state_e  st;
      key_result_t r;
      ev = last_ev;
      st = key_st;
      if (touched) begin
        rel_cnt = '0;
        if (!held_ok) begin
          held_zone = zvalid ? zone : 16'd0;
          held_ok   = zvalid;
        end
        if (zvalid && held_ok && zone == held_zone) begin
          hold_cnt  = hold_cnt + 32'd1;
          last_zone = zone;
          ev        = classify(hold_cnt);
        end else begin
          ev        = EV_EXIT;
          held_ok   = 1'b0;
          held_zone = '0;
        end
      end else begin
        // first untouched tick keeps the old event, the second ends the touch
        rel_cnt = rel_cnt + 2'd1;
        if (rel_cnt == DEBOUNCE_TICKS) begin
          rel_cnt    = '0;
          hold_cnt   = '0;
          ev         = EV_NONE;
          held_ok    = 1'b0;
          held_zone  = '0;
          super_done = 1'b0;
        end
      end
      last_ev = ev;

      case (st)
        KS_RELEASED, KS_CANCEL, KS_IDLE: st = (ev == EV_PRESSED) ? KS_PRESSED : KS_IDLE;
        KS_PRESSED: begin
          if (ev == EV_NONE) st = KS_RELEASED;
          else if (ev == EV_EXIT) st = KS_CANCEL;
          else if (ev == EV_SAME) st = KS_TRANSIT;
          else if (ev == EV_TYPEMATIC) st = KS_TYPEMATIC;
        end
        KS_TYPEMATIC: begin
          if (ev == EV_NONE) st = KS_RELEASED;
          else if (ev == EV_EXIT) st = KS_CANCEL;
          else if (ev == EV_SAME) st = KS_TRANSIT;
        end
        KS_SUPERKEY: begin
          if (ev == EV_NONE) st = KS_RELEASED;
          else if (ev == EV_EXIT) st = KS_CANCEL;
          else if (ev == EV_SAME) st = KS_TRANSIT;
          super_done = 1'b1;
        end
        KS_TRANSIT: begin
          if (ev == EV_NONE) st = KS_RELEASED;
          else if (ev == EV_EXIT) st = KS_CANCEL;
          else if (ev == EV_TYPEMATIC) st = KS_TYPEMATIC;
          else if (ev == EV_SUPERKEY && !super_done) st = KS_SUPERKEY;
        end
        default: ;
      endcase
      key_st = st;

      if (st != KS_IDLE && st != KS_TRANSIT) begin
        r.ev     = st;
        r.widget = last_zone;
        due_q.push_back(r);
      end
    endfunction

    task report(string msg);
      if (n_err < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      n_err++;
    endtask

    task check_result(logic [2:0] ev, logic [15:0] widget);
      key_result_t exp;
      if (due_q.size() == 0) begin
        report($sformatf("beat with nothing due: event %0d widget %h", ev, widget));
        return;
      end
      exp = due_q.pop_front();
      if (ev !== exp.ev)
        report($sformatf("event %0d, wanted %0d", ev, exp.ev));
      if (widget !== exp.widget)
        report($sformatf("widget %h, wanted %h", widget, exp.widget));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_PRESS;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;   // touched, zone_valid
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // widget_id
  logic [2:0]  m_axis_tuser;         // touch_event

  key_event_scoreboard sb;
  bit calm = 1'b0;                   // no idling on either side while set
  int n_sent = 0;
  int rx_wait = 0;
  int idle_cycles = 0;

  touch_press_typematic_fsm uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result side: check each beat, then stall for a drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tuser, m_axis_tdata);
        rx_wait = calm ? 0 : $urandom_range(0, 3);
      end
      if (rx_wait != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // valid stays up straight into the next tick when no gap is drawn
  task send_tick(bit touched, bit zvalid, logic [15:0] zone);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= zone;
    s_axis_tuser  <= {zvalid, touched};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(touched, zvalid, zone);
    n_sent++;
  endtask

  task send_noise();
    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task program_thresholds(logic [15:0] press, logic [15:0] sk, logic [15:0] start,
                          logic [15:0] period);
    logic [15:0] vals [4];
    logic [1:0]  idx  [4];
    vals = '{press, sk, start, period};
    idx  = '{CFG_PRESS, CFG_SUPERKEY, CFG_REPEAT_START, CFG_REPEAT_PER};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_idx_i  <= idx[i];
      cfg_data_i <= vals[i];
      sb.set_reg(idx[i], vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // one press on a zone, sometimes with a single lift inside, then an ending; or else one to six noise ticks
  task key_session(int hold_max);
    logic [15:0] zone;
    int n, brk;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) send_noise();
      return;
    end
    case ($urandom_range(0, 7))
      0:       zone = 16'h0000;
      1:       zone = 16'hFFFF;
      default: zone = 16'($urandom_range(0, 65535));
    endcase
    n   = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, hold_max);
    brk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : 0;
    for (int k = 1; k <= n; k++) begin
      send_tick(1'b1, 1'b1, zone);
      if (k == brk) send_tick(1'b0, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    end
    case ($urandom_range(0, 7))
      0: send_tick(1'b1, 1'b1, zone ^ 16'($urandom_range(1, 65535)));
      1: send_tick(1'b1, 1'b0, 16'($urandom_range(0, 65535)));
      2: ;
      default: begin
        send_tick(1'b0, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        send_tick(1'b0, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end
    endcase
  endtask

  task run_sessions(int count, int hold_max);
    int stop_at;
    stop_at = n_sent + count;
    while (n_sent < stop_at) key_session(hold_max);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset thresholds
    send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b0, 1'b1, 16'hFFFF);
    send_tick(1'b1, 1'b0, 16'h4321);       // first touch off any zone
    send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b0, 1'b0, 16'h0000);
    repeat (3) send_tick(1'b1, 1'b1, 16'h0000);
    repeat (2) send_tick(1'b0, 1'b0, 16'h0000);
    repeat (2) send_tick(1'b1, 1'b1, 16'hFFFF);
    send_tick(1'b1, 1'b1, 16'h0001);       // slide to another zone
    send_tick(1'b1, 1'b1, 16'h0001);
    send_tick(1'b1, 1'b0, 16'h1234);
    repeat (2) send_tick(1'b0, 1'b0, 16'h0000);
    send_tick(1'b1, 1'b1, 16'h5A5A);       // one lift keeps the count going
    send_tick(1'b0, 1'b1, 16'hA5A5);
    send_tick(1'b1, 1'b1, 16'h5A5A);
    repeat (2) send_tick(1'b0, 1'b0, 16'h0000);

    run_sessions(530, 115);
    drain();

    calm = 1'b1;
    program_thresholds(16'd1, 16'hFFFF, 16'd0, 16'd1);
    run_sessions(200, 12);
    drain();

    calm = 1'b0;
    program_thresholds(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    run_sessions(80, 8);

    repeat (4) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      program_thresholds(16'($urandom_range(1, 4)), 16'($urandom_range(1, 30)),
                         16'($urandom_range(0, 12)), 16'($urandom_range(1, 6)));
      run_sessions(230, 40);
    end
    drain();

    if (sb.n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
